### design/aes_cmac_tag_engine_core_assert.svh
// Assertion macros shared by the CMAC tag engine.
// Needs a clock named clk and a reset named rst in the including scope.
`ifndef AES_CMAC_TAG_ENGINE_CORE_ASSERT_SVH
`define AES_CMAC_TAG_ENGINE_CORE_ASSERT_SVH
`define ACMAC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ACMAC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

### design/acmac_pkg.sv
// Shared constants, types and table functions for the CMAC tag engine.
// No dependencies.
package acmac_pkg;

  localparam int unsigned BlockWidth = 128;
  localparam int unsigned Rounds = 10;
  localparam logic [7:0] FoldConst = 8'h87;
  localparam logic [7:0] PadConst = 8'h80;

  localparam logic CfgKeyHigh = 1'b0;
  localparam logic CfgKeyLow = 1'b1;

  typedef struct packed {
    logic busy;
    logic done;
  } aes_status_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] sbox(input logic [7:0] b);
    return SBOX[b];
  endfunction

  function automatic logic [7:0] rcon(input logic [3:0] r);
    logic [7:0] v;
    case (r)
      4'd1: v = 8'h01;
      4'd2: v = 8'h02;
      4'd3: v = 8'h04;
      4'd4: v = 8'h08;
      4'd5: v = 8'h10;
      4'd6: v = 8'h20;
      4'd7: v = 8'h40;
      4'd8: v = 8'h80;
      4'd9: v = 8'h1b;
      4'd10: v = 8'h36;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

endpackage

### design/acmac_aes_unit.sv
// Column-serial AES-128 encryption unit: one 32-bit column per cycle.
// Depends on acmac_pkg for the S-box, round constants and status type.
module acmac_aes_unit (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [127:0]            data,
  input  logic [127:0]            key,
  output acmac_pkg::aes_status_t  status,
  output logic [127:0]            result
);

  logic [127:0] st;
  logic [127:0] nxt;
  logic [127:0] kreg;
  logic [3:0]   rnd;
  logic [1:0]   col;
  logic         busy;
  logic         done;

  logic [7:0]  sb [4];
  logic [31:0] col_out;
  logic [31:0] tmp;
  logic [31:0] new_w;
  logic [31:0] word;
  logic [7:0]  all;
  logic [1:0]  src;
  logic [31:0] w3;

  always_comb begin
    all = 8'h00;
    for (int k = 0; k < 4; k++) begin
      src = col + 2'(k);
      sb[k] = acmac_pkg::sbox(st[127 - 32 * src - 8 * k -: 8]);
      all = all ^ sb[k];
    end
    if (rnd == 4'(acmac_pkg::Rounds)) begin
      col_out = {sb[0], sb[1], sb[2], sb[3]};
    end else begin
      col_out = {sb[0] ^ all ^ acmac_pkg::xtime(sb[0] ^ sb[1]),
                 sb[1] ^ all ^ acmac_pkg::xtime(sb[1] ^ sb[2]),
                 sb[2] ^ all ^ acmac_pkg::xtime(sb[2] ^ sb[3]),
                 sb[3] ^ all ^ acmac_pkg::xtime(sb[3] ^ sb[0])};
    end
    w3 = kreg[31:0];
    if (col == 2'd0) begin
      tmp = {acmac_pkg::sbox(w3[23:16]) ^ acmac_pkg::rcon(rnd), acmac_pkg::sbox(w3[15:8]),
             acmac_pkg::sbox(w3[7:0]), acmac_pkg::sbox(w3[31:24])};
    end else begin
      tmp = w3;
    end
    new_w = kreg[127:96] ^ tmp;
    word = col_out ^ new_w;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      rnd <= 4'd0;
      col <= 2'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        st <= data ^ key;
        kreg <= key;
        rnd <= 4'd1;
        col <= 2'd0;
        busy <= 1'b1;
      end else if (busy) begin
        kreg <= {kreg[95:0], new_w};
        nxt <= {nxt[95:0], word};
        col <= col + 2'd1;
        if (col == 2'd3) begin
          st <= {nxt[95:0], word};
          rnd <= rnd + 4'd1;
          if (rnd == 4'(acmac_pkg::Rounds)) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        end
      end
    end
  end

  assign status = '{busy: busy, done: done};
  assign result = st;

endmodule

### design/aes_cmac_tag_engine_core.sv
// AES-128 CMAC tag engine top level: message sequencing, subkeys and tag register.
// Depends on acmac_pkg, acmac_aes_unit and aes_cmac_tag_engine_core_assert.svh.
//
// Usage: the key is written through the cfg channel (index 0 is the upper key word,
// index 1 the lower) while the engine is idle; cfg_ready is always high.
// Message blocks arrive on the msg channel, one 16-byte word per handshake, with
// is_last on the final word and byte_count giving its valid bytes (0 to 16).
// Each word costs one AES encryption in a column-serial round unit: a load step,
// then each round worked one column at a time, then a done step. The first word
// of a message adds an encryption of the zero block for the subkeys. msg_ready is
// high only while idle. The tag appears on the tag channel after the last word and
// is held in an output register until taken; a following message may start
// meanwhile, and its tag waits inside the engine while the receiver stalls.
// Reset clears the chain, closes any open message and drops tag_valid.
module aes_cmac_tag_engine_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        msg_valid,
  output logic        msg_ready,
  input  logic [63:0] block_high,
  input  logic [63:0] block_low,
  input  logic [4:0]  byte_count,
  input  logic        is_last,
  output logic        tag_valid,
  input  logic        tag_ready,
  output logic [63:0] tag_high,
  output logic [63:0] tag_low
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SUBKEY,
    ST_CHAIN,
    ST_HOLD
  } state_t;

  state_t       state;
  logic [127:0] key;
  logic [127:0] chain;
  logic [127:0] k1;
  logic [127:0] k2;
  logic [127:0] blk;
  logic [4:0]   cnt;
  logic         last;
  logic         open;

  logic         aes_start;
  logic [127:0] aes_data;
  logic [127:0] aes_result;
  acmac_pkg::aes_status_t aes_status;

  logic [127:0] padded;
  logic [127:0] final_blk;
  logic [127:0] k1_next;
  logic [127:0] k2_next;

  function automatic logic [127:0] dbl(input logic [127:0] x);
    return {x[126:0], 1'b0} ^ (x[127] ? {120'd0, acmac_pkg::FoldConst} : 128'd0);
  endfunction

  always_comb begin
    for (int j = 0; j < 16; j++) begin
      if (5'(j) < cnt) begin
        padded[127 - 8 * j -: 8] = blk[127 - 8 * j -: 8];
      end else if (5'(j) == cnt) begin
        padded[127 - 8 * j -: 8] = acmac_pkg::PadConst;
      end else begin
        padded[127 - 8 * j -: 8] = 8'h00;
      end
    end
    if (!last) begin
      final_blk = blk;
    end else if (cnt >= 5'd16) begin
      final_blk = blk ^ k1;
    end else begin
      final_blk = padded ^ k2;
    end
    k1_next = dbl(aes_result);
    k2_next = dbl(k1_next);
    aes_start = (state == ST_LOAD);
    aes_data = open ? (chain ^ final_blk) : 128'd0;
  end

  acmac_aes_unit u_aes (
    .clk    (clk),
    .rst    (rst),
    .start  (aes_start),
    .data   (aes_data),
    .key    (key),
    .status (aes_status),
    .result (aes_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      key <= 128'd0;
      chain <= 128'd0;
      open <= 1'b0;
      tag_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == acmac_pkg::CfgKeyHigh) begin
          key[127:64] <= cfg_data;
        end else begin
          key[63:0] <= cfg_data;
        end
      end
      if (state == ST_HOLD && (!tag_valid || tag_ready)) begin
        tag_valid <= 1'b1;
      end else if (tag_valid && tag_ready) begin
        tag_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (msg_valid) begin
            blk <= {block_high, block_low};
            cnt <= byte_count;
            last <= is_last;
            state <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          state <= open ? ST_CHAIN : ST_SUBKEY;
        end
        ST_SUBKEY: begin
          if (aes_status.done) begin
            k1 <= k1_next;
            k2 <= k2_next;
            chain <= 128'd0;
            open <= 1'b1;
            state <= ST_LOAD;
          end
        end
        ST_CHAIN: begin
          if (aes_status.done) begin
            if (!last) begin
              chain <= aes_result;
              state <= ST_IDLE;
            end else begin
              state <= ST_HOLD;
            end
          end
        end
        ST_HOLD: begin
          if (!tag_valid || tag_ready) begin
            {tag_high, tag_low} <= aes_result;
            chain <= 128'd0;
            open <= 1'b0;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign cfg_ready = 1'b1;
  assign msg_ready = (state == ST_IDLE);

`include "aes_cmac_tag_engine_core_assert.svh"

  `ACMAC_ASSERT_NEXT(a_accept_busy, msg_valid && msg_ready, !msg_ready, "accepted while busy")
  `ACMAC_ASSERT_IMPL(a_done_owned, aes_status.done, state == ST_SUBKEY || state == ST_CHAIN, "stray AES done")
  `ACMAC_ASSERT_IMPL(a_tag_source, $rose(tag_valid), $past(state == ST_HOLD), "tag without final block")

endmodule
